>>> design/sbsm_pkg.sv
// Shared types and constants for the serial bank-switch mapper.
// No dependencies; imported by serial_bank_switch_mapper and its testbench.
package sbsm_pkg;

    // Access kinds carried on the input tuser
    typedef enum logic [1:0] {
        KIND_CPU_RD = 2'd0,
        KIND_CPU_WR = 2'd1,
        KIND_PPU_RD = 2'd2,
        KIND_PPU_WR = 2'd3
    } t_kind;

    // Target memories carried on the output tuser
    typedef enum logic [1:0] {
        TGT_NONE    = 2'd0,
        TGT_PRG_RAM = 2'd1,
        TGT_PRG_ROM = 2'd2,
        TGT_CHR_ROM = 2'd3
    } t_target;

    // Mapper register selected by CPU address bits 14..13
    typedef enum logic [1:0] {
        MREG_CONTROL = 2'd0,
        MREG_CHR0    = 2'd1,
        MREG_CHR1    = 2'd2,
        MREG_PRG     = 2'd3
    } t_mreg;

    // Configuration register indexes
    localparam logic REG_PRG_BANK_COUNT = 1'b0;

    // Field widths
    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int MADDR_W  = 18;
    localparam int SHIFT_W  = 5;
    localparam int COUNT_W  = 5;
    localparam int PRG_SEL_W = 4;

    // Reset values and mode codes
    localparam logic [SHIFT_W-1:0] SHIFT_EMPTY   = 5'h10;
    localparam logic [1:0]         PRG_MODE_FIX_LAST = 2'd3;
    localparam logic [1:0]         PRG_MODE_FIX_FIRST = 2'd2;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = 5'd16;

    // Result item held in the output register
    typedef struct packed {
        t_target             target;
        logic [MADDR_W-1:0]  mapped_addr;
        logic                write_enable;
        logic [DATA_W-1:0]   write_data;
        logic [1:0]          mirror_mode;
        logic                ram_enable_flag;
    } t_result;

endpackage

>>> design/serial_bank_switch_mapper.sv
// Serial bank-switch mapper: bus access translator with APB configuration.
// Depends on sbsm_pkg (types, codes, widths).
//
// Translates CPU and PPU bus accesses into a target memory and a byte offset,
// and keeps the serial-loaded bank registers of an MMC1-style cartridge. A
// request is taken into an input register, translated and applied to the
// mapper state as it moves into an output register. The sustained rate is one
// request per cycle while the result stream keeps taking results, set by the
// single translate stage between those two registers. The input side keeps
// accepting while a result waits, as long as the input register can drain.
// Bank count is written over APB at byte address 0 and should only change
// while no request is in flight.
module serial_bank_switch_mapper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [15:0] addr, [23:16] data
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [17:0] mapped_addr, [18] write_enable,
                                        // [26:19] write_data, [28:27] mirror_mode,
                                        // [29] ram_enable_flag, [31:30] zero
    output logic [1:0]  m_axis_tuser    // [1:0] target
);
    import sbsm_pkg::*;

    // Configuration
    logic [COUNT_W-1:0]   r_prg_bank_count;

    // Mapper state
    logic [SHIFT_W-1:0]   r_shift, n_shift;
    logic [1:0]           r_mirror, n_mirror;
    logic [1:0]           r_prg_mode, n_prg_mode;
    logic                 r_chr_mode, n_chr_mode;
    logic [4:0]           r_chr_low, n_chr_low;
    logic [4:0]           r_chr_high, n_chr_high;
    logic [PRG_SEL_W-1:0] r_prg_sel, n_prg_sel;
    logic                 r_ram_en, n_ram_en;

    // Pipeline registers
    logic                 r_in_vld;
    t_kind                r_kind;
    logic [ADDR_W-1:0]    r_addr;
    logic [DATA_W-1:0]    r_data;
    logic                 r_out_vld;
    t_result              r_out, n_out;

    logic                 adv;
    logic                 cfg_wr;
    logic [COUNT_W-1:0]   count_clamped;
    logic [PRG_SEL_W-1:0] last_bank;
    logic [MADDR_W-1:0]   prg_off;
    logic [MADDR_W-1:0]   chr_off;
    logic [SHIFT_W-1:0]   shifted;

    // APB: always ready, one register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_PRG_BANK_COUNT)
                  ? {{(32-COUNT_W){1'b0}}, r_prg_bank_count} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_bank_count <= COUNT_MAX;
        end else if (cfg_wr && paddr[2] == REG_PRG_BANK_COUNT) begin
            r_prg_bank_count <= pwdata[COUNT_W-1:0];
        end
    end

    // Handshake: advance the input register when the output can take it
    assign adv           = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    // Capture request payload
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_kind <= t_kind'(s_axis_tuser);
            r_addr <= s_axis_tdata[ADDR_W-1:0];
            r_data <= s_axis_tdata[ADDR_W+DATA_W-1:ADDR_W];
        end
    end

    // Clamp bank count to 1..16 and pick the fixed last bank
    always_comb begin
        if (r_prg_bank_count == '0) begin
            count_clamped = 5'd1;
        end else if (r_prg_bank_count > COUNT_MAX) begin
            count_clamped = COUNT_MAX;
        end else begin
            count_clamped = r_prg_bank_count;
        end
        last_bank = PRG_SEL_W'(count_clamped - 5'd1);
    end

    // Program ROM window offset
    always_comb begin
        if (!r_prg_mode[1]) begin
            prg_off = {r_prg_sel[3:1], r_addr[14:0]};
        end else if (!r_addr[14]) begin
            prg_off = (r_prg_mode == PRG_MODE_FIX_FIRST)
                    ? {4'd0, r_addr[13:0]} : {r_prg_sel, r_addr[13:0]};
        end else begin
            prg_off = (r_prg_mode == PRG_MODE_FIX_FIRST)
                    ? {r_prg_sel, r_addr[13:0]} : {last_bank, r_addr[13:0]};
        end
    end

    // Character ROM window offset
    always_comb begin
        if (!r_chr_mode) begin
            chr_off = {1'b0, r_chr_low[4:1], r_addr[12:0]};
        end else if (!r_addr[12]) begin
            chr_off = {1'b0, r_chr_low, r_addr[11:0]};
        end else begin
            chr_off = {1'b0, r_chr_high, r_addr[11:0]};
        end
    end

    // Serial load: shift data bit 0 in at the top, commit on the fifth write
    assign shifted = {r_data[0], r_shift[SHIFT_W-1:1]};

    always_comb begin
        n_shift    = r_shift;
        n_mirror   = r_mirror;
        n_prg_mode = r_prg_mode;
        n_chr_mode = r_chr_mode;
        n_chr_low  = r_chr_low;
        n_chr_high = r_chr_high;
        n_prg_sel  = r_prg_sel;
        n_ram_en   = r_ram_en;
        if (r_kind == KIND_CPU_WR && r_addr[15]) begin
            if (r_data[7]) begin
                n_shift    = SHIFT_EMPTY;
                n_prg_mode = PRG_MODE_FIX_LAST;
            end else if (!r_shift[0]) begin
                n_shift = shifted;
            end else begin
                n_shift = SHIFT_EMPTY;
                unique case (t_mreg'(r_addr[14:13]))
                    MREG_CONTROL: begin
                        n_chr_mode = shifted[4];
                        n_prg_mode = shifted[3:2];
                        n_mirror   = shifted[1:0];
                    end
                    MREG_CHR0: n_chr_low  = shifted;
                    MREG_CHR1: n_chr_high = shifted;
                    MREG_PRG: begin
                        n_prg_sel = shifted[3:0];
                        n_ram_en  = shifted[4];
                    end
                    default: n_shift = SHIFT_EMPTY;
                endcase
            end
        end
    end

    // Translate the access into a result
    always_comb begin
        n_out.target          = TGT_NONE;
        n_out.mapped_addr     = '0;
        n_out.write_enable    = 1'b0;
        n_out.write_data      = '0;
        n_out.mirror_mode     = n_mirror;
        n_out.ram_enable_flag = n_ram_en;
        unique case (r_kind)
            KIND_CPU_RD: begin
                if (r_addr[15]) begin
                    n_out.target      = TGT_PRG_ROM;
                    n_out.mapped_addr = prg_off;
                end else if (r_addr[14:13] == 2'b11) begin
                    n_out.target      = TGT_PRG_RAM;
                    n_out.mapped_addr = {5'd0, r_addr[12:0]};
                end
            end
            KIND_CPU_WR: begin
                if (!r_addr[15] && r_addr[14:13] == 2'b11) begin
                    n_out.target       = TGT_PRG_RAM;
                    n_out.mapped_addr  = {5'd0, r_addr[12:0]};
                    n_out.write_enable = 1'b1;
                    n_out.write_data   = r_data;
                end
            end
            KIND_PPU_RD: begin
                if (r_addr[15:13] == 3'b000) begin
                    n_out.target      = TGT_CHR_ROM;
                    n_out.mapped_addr = chr_off;
                end
            end
            KIND_PPU_WR: n_out.target = TGT_NONE;
            default:     n_out.target = TGT_NONE;
        endcase
    end

    // Update mapper state as each request advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift    <= SHIFT_EMPTY;
            r_mirror   <= 2'd0;
            r_prg_mode <= PRG_MODE_FIX_LAST;
            r_chr_mode <= 1'b0;
            r_chr_low  <= 5'd0;
            r_chr_high <= 5'd0;
            r_prg_sel  <= '0;
            r_ram_en   <= 1'b1;
        end else if (adv) begin
            r_shift    <= n_shift;
            r_mirror   <= n_mirror;
            r_prg_mode <= n_prg_mode;
            r_chr_mode <= n_chr_mode;
            r_chr_low  <= n_chr_low;
            r_chr_high <= n_chr_high;
            r_prg_sel  <= n_prg_sel;
            r_ram_en   <= n_ram_en;
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out.target;
    assign m_axis_tdata  = {2'b00, r_out.ram_enable_flag, r_out.mirror_mode,
                            r_out.write_data, r_out.write_enable, r_out.mapped_addr};

`ifndef SYNTHESIS
    // The marker bit never leaves the shift register
    a_shift_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_shift != '0)
        else $error("shift register lost its marker bit");

    // A RAM write strobe only goes with a program RAM target
    a_we_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.write_enable) |-> (r_out.target == TGT_PRG_RAM))
        else $error("write enable without program RAM target");

    // A reset write forces the fixed-last program mode
    a_reset_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_kind == KIND_CPU_WR && r_addr[15] && r_data[7])
        |=> (r_prg_mode == PRG_MODE_FIX_LAST && r_shift == SHIFT_EMPTY))
        else $error("reset write did not clear shift register and mode");
`endif

endmodule

>>> sim/serial_bank_switch_mapper_tb.sv
`timescale 1ns / 100ps
// Testbench for serial_bank_switch_mapper: directed and random bus requests,
// a cycle-free translation predictor and a checker on the result stream.
// Depends on sbsm_pkg and serial_bank_switch_mapper.
module serial_bank_switch_mapper_tb;
    import sbsm_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 5;
    localparam int DRAIN_CYCLES = 6;
    localparam int QUIET_LIMIT  = 2000;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASE_ITEMS  = 270;

    localparam int         SPARE_REG_INDEX = 1;
    localparam logic [2:0] BANK_COUNT_ADDR = 3'(4 * int'(REG_PRG_BANK_COUNT));
    localparam logic [2:0] SPARE_ADDR      = 3'(4 * SPARE_REG_INDEX);

    // Bus map of the cartridge
    localparam logic [15:0] RAM_BASE       = 16'h6000;
    localparam logic [15:0] ROM_BASE       = 16'h8000;
    localparam logic [15:0] ROM_UPPER      = 16'hC000;
    localparam logic [15:0] PATTERN_END    = 16'h2000;
    localparam logic [15:0] CHR_HALF       = 16'h1000;
    localparam int          PRG_BANK_BYTES = 'h4000;
    localparam int          CHR_BANK_BYTES = 'h1000;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // [15:0] addr, [23:16] data
    logic [1:0]  s_axis_tuser;   // [1:0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [17:0] mapped_addr, [18] write_enable,
                                 // [26:19] write_data, [28:27] mirror_mode,
                                 // [29] ram_enable_flag, [31:30] zero
    logic [1:0]  m_axis_tuser;   // [1:0] target

    // Predicted mapper state
    logic [SHIFT_W-1:0]   serial_acc;
    logic [1:0]           mirror_sel;
    logic [1:0]           prg_win_mode;
    logic                 chr_win_mode;
    logic [4:0]           chr_lo_bank;
    logic [4:0]           chr_hi_bank;
    logic [PRG_SEL_W-1:0] prg_switch_bank;
    logic                 ram_en_bit;
    logic [COUNT_W-1:0]   rom_banks;

    t_result expected_maps[$];
    int      failures;
    int      src_idle_pct;
    int      sink_idle_pct;

    serial_bank_switch_mapper i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic void log_failure(string msg);
        failures++;
        if (failures <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endfunction

    // Translate one request and advance the predicted mapper state
    function automatic t_result translate_access(t_kind kind, logic [15:0] addr,
                                                 logic [7:0] data);
        t_result res;
        int      a;
        int      banks;
        int      offset;
        logic    full;
        res    = '0;
        a      = int'(addr);
        offset = 0;
        case (kind)
            KIND_CPU_RD, KIND_CPU_WR: begin
                if (addr >= ROM_BASE && kind == KIND_CPU_WR) begin
                    // Serial port: bit 7 clears, else shift bit 0 in from the top
                    if (data[7]) begin
                        serial_acc   = SHIFT_EMPTY;
                        prg_win_mode = PRG_MODE_FIX_LAST;
                    end else begin
                        full       = serial_acc[0];
                        serial_acc = {data[0], serial_acc[SHIFT_W-1:1]};
                        if (full) begin
                            case (t_mreg'(addr[14:13]))
                                MREG_CONTROL: {chr_win_mode, prg_win_mode, mirror_sel} = serial_acc;
                                MREG_CHR0:    chr_lo_bank = serial_acc;
                                MREG_CHR1:    chr_hi_bank = serial_acc;
                                default:      {ram_en_bit, prg_switch_bank} = serial_acc;
                            endcase
                            serial_acc = SHIFT_EMPTY;
                        end
                    end
                end else if (addr >= ROM_BASE) begin
                    res.target = TGT_PRG_ROM;
                    banks = (rom_banks == 0) ? 1 :
                            (rom_banks > COUNT_MAX) ? int'(COUNT_MAX) : int'(rom_banks);
                    if (prg_win_mode < PRG_MODE_FIX_FIRST) begin
                        offset = int'(prg_switch_bank & 4'hE) * PRG_BANK_BYTES
                                 + a - int'(ROM_BASE);
                    end else if (addr < ROM_UPPER) begin
                        offset = (prg_win_mode == PRG_MODE_FIX_FIRST ? 0 :
                                  int'(prg_switch_bank) * PRG_BANK_BYTES)
                                 + a - int'(ROM_BASE);
                    end else begin
                        offset = (prg_win_mode == PRG_MODE_FIX_FIRST ?
                                  int'(prg_switch_bank) : banks - 1) * PRG_BANK_BYTES
                                 + a - int'(ROM_UPPER);
                    end
                end else if (addr >= RAM_BASE) begin
                    res.target = TGT_PRG_RAM;
                    offset     = a - int'(RAM_BASE);
                    if (kind == KIND_CPU_WR) begin
                        res.write_enable = 1'b1;
                        res.write_data   = data;
                    end
                end
            end
            KIND_PPU_RD: begin
                if (addr < PATTERN_END) begin
                    res.target = TGT_CHR_ROM;
                    if (!chr_win_mode) begin
                        offset = int'(chr_lo_bank & 5'h1E) * CHR_BANK_BYTES + a;
                    end else if (addr < CHR_HALF) begin
                        offset = int'(chr_lo_bank) * CHR_BANK_BYTES + a;
                    end else begin
                        offset = int'(chr_hi_bank) * CHR_BANK_BYTES + a - int'(CHR_HALF);
                    end
                end
            end
            default: begin
                // PPU writes map to nothing
            end
        endcase
        res.mapped_addr     = MADDR_W'(offset);
        res.mirror_mode     = mirror_sel;
        res.ram_enable_flag = ram_en_bit;
        return res;
    endfunction

    // Check each result against the oldest prediction, then record new requests
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.target          = t_target'(m_axis_tuser);
            got.mapped_addr     = m_axis_tdata[17:0];
            got.write_enable    = m_axis_tdata[18];
            got.write_data      = m_axis_tdata[26:19];
            got.mirror_mode     = m_axis_tdata[28:27];
            got.ram_enable_flag = m_axis_tdata[29];
            if (expected_maps.size() == 0) begin
                log_failure($sformatf("unexpected result: tuser=%h tdata=%h",
                                      m_axis_tuser, m_axis_tdata));
            end else begin
                want = expected_maps.pop_front();
                if (got !== want || m_axis_tdata[31:30] !== 2'b00) begin
                    log_failure($sformatf(
                        {"map mismatch: exp tgt=%0d off=%05h we=%b wd=%02h mir=%0d ren=%b",
                         " | got tgt=%0d off=%05h we=%b wd=%02h mir=%0d ren=%b pad=%b"},
                        want.target, want.mapped_addr, want.write_enable,
                        want.write_data, want.mirror_mode, want.ram_enable_flag,
                        got.target, got.mapped_addr, got.write_enable,
                        got.write_data, got.mirror_mode, got.ram_enable_flag,
                        m_axis_tdata[31:30]));
                end
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            expected_maps.push_back(translate_access(t_kind'(s_axis_tuser),
                                                     s_axis_tdata[15:0],
                                                     s_axis_tdata[23:16]));
        end
    end

    // Random back-pressure on the result side
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // End the run when no handshake of any kind happens for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (psel && penable)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("serial_bank_switch_mapper verification failed");
        $finish;
    end

    // Send one request, with random idle cycles ahead of it
    task automatic issue_access(t_kind kind, logic [15:0] addr, logic [7:0] data);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {data, addr};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Shift a value into the serial port, low bit first; the fifth write picks the register
    task automatic serial_load(t_mreg region, logic [4:0] value, int n_bits);
        logic [15:0] addr;
        for (int i = 0; i < n_bits; i++) begin
            if (i == SHIFT_W - 1) begin
                addr = {1'b1, region, 13'($urandom)};
            end else begin
                addr = ROM_BASE | 16'($urandom);
            end
            issue_access(KIND_CPU_WR, addr, {1'b0, 6'($urandom), value[i]});
        end
    endtask

    // Hold requests off until every outstanding result is back
    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_maps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One APB transfer, then a return to the idle state
    task automatic apb_transfer(logic wr, logic [2:0] addr, logic [31:0] wdata,
                                output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Program the bank count while idle and read it back
    task automatic set_bank_count(logic [COUNT_W-1:0] value);
        logic [31:0] rd;
        wait_until_drained();
        apb_transfer(1'b1, BANK_COUNT_ADDR, 32'(value), rd);
        rom_banks = value;
        apb_transfer(1'b0, BANK_COUNT_ADDR, '0, rd);
        if (rd !== 32'(value)) begin
            log_failure($sformatf("bank count readback: exp %h got %h", 32'(value), rd));
        end
    endtask

    // Window edges, ignored regions and the serial reset
    task automatic test_directed_accesses();
        issue_access(KIND_CPU_RD, 16'h0000, 8'h00);
        issue_access(KIND_CPU_RD, 16'h5FFF, 8'hFF);
        issue_access(KIND_CPU_RD, 16'h6000, 8'h00);
        issue_access(KIND_CPU_RD, 16'h7FFF, 8'h00);
        issue_access(KIND_CPU_WR, 16'h6000, 8'hFF);
        issue_access(KIND_CPU_WR, 16'h7FFF, 8'h00);
        issue_access(KIND_CPU_WR, 16'h0000, 8'hAA);
        issue_access(KIND_CPU_WR, 16'h5FFF, 8'h55);
        issue_access(KIND_CPU_RD, 16'h8000, 8'h00);
        issue_access(KIND_CPU_RD, 16'hFFFF, 8'h00);
        issue_access(KIND_PPU_RD, 16'h0000, 8'h00);
        issue_access(KIND_PPU_RD, 16'h1FFF, 8'h00);
        issue_access(KIND_PPU_RD, 16'h2000, 8'h00);
        issue_access(KIND_PPU_RD, 16'hFFFF, 8'h00);
        issue_access(KIND_PPU_WR, 16'h0000, 8'hFF);
        issue_access(KIND_CPU_WR, 16'h8000, 8'h80);
        // 4 KiB character windows, fixed-first program layout, mirroring 3
        serial_load(MREG_CONTROL, 5'b11011, SHIFT_W);
        issue_access(KIND_CPU_RD, 16'hC000, 8'h00);
        issue_access(KIND_PPU_RD, 16'h1000, 8'h00);
        issue_access(KIND_CPU_WR, 16'hFFFF, 8'hFF);
    endtask

    // A write to the unused register slot must leave the mapping alone
    task automatic test_spare_register();
        logic [31:0] rd;
        wait_until_drained();
        apb_transfer(1'b1, SPARE_ADDR, $urandom, rd);
        issue_access(KIND_CPU_RD, 16'hC000, 8'h00);
        issue_access(KIND_CPU_RD, 16'hFFFF, 8'h00);
    endtask

    // Mostly well-formed register loads mixed with reads, plus broken sequences and noise
    task automatic test_random_mapping(logic [COUNT_W-1:0] banks, int n_items);
        int          issued;
        int          pick;
        t_kind       kind;
        logic [15:0] addr;
        set_bank_count(banks);
        issued = 0;
        while (issued < n_items) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                serial_load(t_mreg'($urandom_range(3)), 5'($urandom), SHIFT_W);
                issued += SHIFT_W;
            end else if (pick < 40) begin
                // partial load, left hanging or cut off by a serial reset
                serial_load(t_mreg'($urandom_range(3)), 5'($urandom), $urandom_range(4, 1));
                if ($urandom_range(1) == 1) begin
                    issue_access(KIND_CPU_WR, ROM_BASE | 16'($urandom), 8'h80 | 8'($urandom));
                end
                issued += 3;
            end else if (pick < 70) begin
                issue_access(KIND_CPU_RD, ROM_BASE | 16'($urandom), 8'($urandom));
                issued++;
            end else if (pick < 82) begin
                kind = ($urandom_range(1) == 1) ? KIND_CPU_WR : KIND_CPU_RD;
                addr = 16'($urandom_range(16'h7FFF));
                issue_access(kind, addr, 8'($urandom));
                if (kind == KIND_CPU_RD || addr >= RAM_BASE) begin
                    issued++;
                end
            end else if (pick < 95) begin
                addr = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(16'h1FFF));
                issue_access(KIND_PPU_RD, addr, 8'($urandom));
                issued++;
            end else begin
                issue_access(KIND_PPU_WR, 16'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= KIND_CPU_RD;

        serial_acc      = SHIFT_EMPTY;
        mirror_sel      = '0;
        prg_win_mode    = PRG_MODE_FIX_LAST;
        chr_win_mode    = 1'b0;
        chr_lo_bank     = '0;
        chr_hi_bank     = '0;
        prg_switch_bank = '0;
        ram_en_bit      = 1'b1;
        rom_banks       = COUNT_MAX;
        failures        = 0;
        src_idle_pct    = 36;
        sink_idle_pct   = 59;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_accesses();
        test_spare_register();
        test_random_mapping(5'd1, PHASE_ITEMS);
        test_random_mapping(COUNT_MAX, PHASE_ITEMS);

        src_idle_pct  = 59;
        sink_idle_pct = 36;
        test_random_mapping(5'd0, PHASE_ITEMS);
        test_random_mapping(5'd31, PHASE_ITEMS);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_mapping(5'($urandom_range(15, 2)), PHASE_ITEMS);
        test_random_mapping(5'($urandom_range(30, 17)), PHASE_ITEMS);

        wait_until_drained();
        failures += expected_maps.size();
        if (failures == 0) begin
            $display("serial_bank_switch_mapper verification clean");
        end else begin
            $display("serial_bank_switch_mapper verification failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/sbsm_pkg.sv
design/serial_bank_switch_mapper.sv
sim/serial_bank_switch_mapper_tb.sv
